### src/lerq_pkg.sv
// ----------------------------------------------------------------------------
// lerq_pkg: shared types and helpers for the LOOK elevator request queue
// Request and result formats, status codes, cell handoff records and the
// sweep ordering key.
// ----------------------------------------------------------------------------
package lerq_pkg;

    // Sizes
    localparam int QUEUE_DEPTH = 16;
    localparam int TRACK_MAX   = 99;
    localparam int TRK_W       = 7;
    localparam int TAG_W       = 16;
    localparam int LEN_W       = 5;
    localparam int CNT_W       = $clog2(QUEUE_DEPTH + 1);
    localparam int SPAN        = TRACK_MAX + 1;
    localparam int KEY_W       = $clog2(2 * SPAN);

    // Operation and status codes
    typedef enum logic [0:0] {
        OP_ADD = 1'b0,
        OP_GET = 1'b1
    } t_opcode;

    typedef enum logic [1:0] {
        ST_OK    = 2'd0,
        ST_EMPTY = 2'd1,
        ST_FULL  = 2'd2
    } t_status;

    // Request and result payloads
    typedef struct packed {
        t_opcode          opcode;
        logic [TRK_W-1:0] req_track;
        logic [TAG_W-1:0] req_tag;
    } t_req;

    typedef struct packed {
        t_status          status;
        logic [TRK_W-1:0] served_track;
        logic [TAG_W-1:0] served_tag;
        logic [LEN_W-1:0] queue_length;
        logic             moving_up;
    } t_res;

    // One stored entry
    typedef struct packed {
        logic [TRK_W-1:0] track;
        logic [TAG_W-1:0] tag;
    } t_entry;

    // Entry travelling down the chain during an insert
    typedef struct packed {
        logic   valid;
        logic   placed;
        t_entry ent;
    } t_carry;

    // Broadcast control from the top level to every cell
    typedef struct packed {
        logic             shift;
        logic             head_known;
        logic             sweep_up;
        logic [TRK_W-1:0] head_track;
        logic [CNT_W-1:0] fill;
    } t_cell_ctl;

    // Ordering key: group 0 is the remaining sweep, group 1 the return sweep
    function automatic logic [KEY_W-1:0] sweep_key(
        input logic [TRK_W-1:0] trk,
        input logic [TRK_W-1:0] head,
        input logic             up
    );
        logic [KEY_W-1:0] k;
        if (up) begin
            if (trk >= head) begin
                k = KEY_W'(trk);
            end else begin
                k = KEY_W'(SPAN) + (KEY_W'(TRACK_MAX) - KEY_W'(trk));
            end
        end else begin
            if (trk <= head) begin
                k = KEY_W'(TRACK_MAX) - KEY_W'(trk);
            end else begin
                k = KEY_W'(SPAN) + KEY_W'(trk);
            end
        end
        return k;
    endfunction

endpackage

### src/lerq_cell.sv
// ----------------------------------------------------------------------------
// lerq_cell: one slot of the request chain
// Holds one entry. On an insert it either passes the request on to the next
// cell or takes it and hands its own entry, if it holds one, onward; on a get
// it takes the entry of the next cell.
// ----------------------------------------------------------------------------
module lerq_cell (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic [lerq_pkg::CNT_W-1:0] i_idx,
    input  lerq_pkg::t_cell_ctl        i_ctl,
    input  lerq_pkg::t_carry           i_carry,
    input  lerq_pkg::t_entry           i_next,
    output lerq_pkg::t_carry           o_carry,
    output lerq_pkg::t_entry           o_entry
);
    import lerq_pkg::*;

    t_entry           r_entry;
    t_carry           r_carry;
    logic             w_occ;
    logic             w_gt;
    logic             w_take;
    logic [KEY_W-1:0] w_key_own;
    logic [KEY_W-1:0] w_key_in;

    // Decide whether the passing request lands here
    always_comb begin
        w_occ     = i_idx < i_ctl.fill;
        w_key_own = sweep_key(r_entry.track, i_ctl.head_track, i_ctl.sweep_up);
        w_key_in  = sweep_key(i_carry.ent.track, i_ctl.head_track, i_ctl.sweep_up);
        w_gt      = i_ctl.head_known && (w_key_own > w_key_in);
        w_take    = i_carry.valid && (i_carry.placed || !w_occ || w_gt);
    end

    // Track whether a request is moving on to the next cell, and what it carries
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_carry.valid <= 1'b0;
        end else if (w_take) begin
            r_carry.valid <= w_occ;
        end else begin
            r_carry.valid <= i_carry.valid;
        end
        if (w_take) begin
            r_carry.placed <= 1'b1;
            r_carry.ent    <= r_entry;
        end else begin
            r_carry.placed <= i_carry.placed;
            r_carry.ent    <= i_carry.ent;
        end
    end

    // Swap or pass the entry, or advance on a get
    always_ff @(posedge i_clk) begin
        if (i_ctl.shift) begin
            r_entry <= i_next;
        end else if (w_take) begin
            r_entry <= i_carry.ent;
        end
    end

    assign o_carry = r_carry;
    assign o_entry = r_entry;

endmodule

### src/look_elevator_request_queue.sv
// ----------------------------------------------------------------------------
// look_elevator_request_queue: LOOK (elevator) disk request queue
// Result strobe comes in the cycle after a request is accepted; the receiver
// cannot stall it. A get holds busy low: next request may follow at once.
// An add walks the cell chain one cell per cycle: busy stays high while the
// displaced entries move on through the cells already holding requests.
// Synchronous reset empties the queue, forgets the head and sweeps upward.
// ----------------------------------------------------------------------------
module look_elevator_request_queue (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           start,
    input  lerq_pkg::t_req i_req,
    output logic           busy,
    output logic           o_strobe,
    output lerq_pkg::t_res o_res
);
    import lerq_pkg::*;

    logic [CNT_W-1:0] r_count, n_count;
    logic [TRK_W-1:0] r_head, n_head;
    logic             r_known, n_known;
    logic             r_up, n_up;
    logic             r_strobe;
    t_res             r_res, n_res;

    t_carry     w_cin  [QUEUE_DEPTH];
    t_carry     w_cout [QUEUE_DEPTH];
    t_entry     w_ent  [QUEUE_DEPTH];
    t_entry     w_nxt  [QUEUE_DEPTH];
    logic [QUEUE_DEPTH-1:0] w_moving;

    logic             w_acc;
    logic             w_get;
    logic             w_add_ok;
    logic             w_get_ok;
    logic [TRK_W-1:0] w_trk;
    t_cell_ctl        w_ctl;
    t_carry           w_inject;

    // Request accept and saturation of the incoming track
    always_comb begin
        w_acc    = start && !busy;
        w_get    = i_req.opcode == OP_GET;
        w_add_ok = w_acc && !w_get && (r_count != CNT_W'(QUEUE_DEPTH));
        w_get_ok = w_acc && w_get && (r_count != '0);
        w_trk    = (i_req.req_track > TRK_W'(TRACK_MAX)) ? TRK_W'(TRACK_MAX)
                                                         : i_req.req_track;
    end

    // Feed the chain
    always_comb begin
        w_inject.valid     = w_add_ok;
        w_inject.placed    = 1'b0;
        w_inject.ent.track = w_trk;
        w_inject.ent.tag   = i_req.req_tag;
        w_ctl.shift        = w_get_ok;
        w_ctl.head_known   = r_known;
        w_ctl.sweep_up     = r_up;
        w_ctl.head_track   = r_head;
        w_ctl.fill         = r_count - CNT_W'(busy);
    end

    // Cell chain
    genvar g;
    generate
        for (g = 0; g < QUEUE_DEPTH; g++) begin : g_cell
            if (g == 0) begin : g_first
                assign w_cin[g] = w_inject;
            end else begin : g_rest
                assign w_cin[g] = w_cout[g-1];
            end
            if (g == QUEUE_DEPTH - 1) begin : g_last
                assign w_nxt[g] = '0;
            end else begin : g_mid
                assign w_nxt[g] = w_ent[g+1];
            end
            assign w_moving[g] = w_cout[g].valid;

            lerq_cell u_cell (
                .i_clk   (i_clk),
                .i_rst_n (i_rst_n),
                .i_idx   (CNT_W'(g)),
                .i_ctl   (w_ctl),
                .i_carry (w_cin[g]),
                .i_next  (w_nxt[g]),
                .o_carry (w_cout[g]),
                .o_entry (w_ent[g])
            );
        end
    endgenerate

    assign busy = |w_moving;

    // Next queue state and result
    always_comb begin
        n_count = r_count;
        n_head  = r_head;
        n_known = r_known;
        n_up    = r_up;
        n_res   = '0;
        if (w_add_ok) begin
            n_count = r_count + CNT_W'(1);
        end
        if (w_get_ok) begin
            n_count = r_count - CNT_W'(1);
            n_head  = w_ent[0].track;
            n_known = 1'b1;
            if (r_known && (w_ent[0].track > r_head)) begin
                n_up = 1'b1;
            end else if (r_known && (w_ent[0].track < r_head)) begin
                n_up = 1'b0;
            end
            n_res.served_track = w_ent[0].track;
            n_res.served_tag   = w_ent[0].tag;
        end
        if (w_acc && w_get && !w_get_ok) begin
            n_res.status = ST_EMPTY;
        end else if (w_acc && !w_get && !w_add_ok) begin
            n_res.status = ST_FULL;
        end else begin
            n_res.status = ST_OK;
        end
        n_res.queue_length = LEN_W'(n_count);
        n_res.moving_up    = n_up;
    end

    // Control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count  <= '0;
            r_head   <= '0;
            r_known  <= 1'b0;
            r_up     <= 1'b1;
            r_strobe <= 1'b0;
        end else begin
            r_count  <= n_count;
            r_head   <= n_head;
            r_known  <= n_known;
            r_up     <= n_up;
            r_strobe <= w_acc;
        end
    end

    // Hold the result for its strobe cycle
    always_ff @(posedge i_clk) begin
        if (w_acc) begin
            r_res <= n_res;
        end
    end

    assign o_strobe = r_strobe;
    assign o_res    = r_res;

endmodule
